// ----- rtl/fogvis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fogvis_pkg
// Shared constants and types for the fog visibility evaluator.
// ----------------------------------------------------------------------------
package fogvis_pkg;

  localparam int LUT_SIZE   = 128;
  localparam int CLEAR_KNOT = 2;
  localparam int VALUE_BITS = 11;

  localparam int FX_BITS   = 16;                  // 1/65536 fraction bits
  localparam int ENTRY_W   = $clog2(LUT_SIZE);    // 7
  localparam int FX_W      = FX_BITS + 1;         // 0..65536
  localparam int POS_W     = ENTRY_W + FX_BITS + 1;
  localparam int QUO_W     = POS_W;               // quotient bits resolved
  localparam int DIST_W    = 16;
  localparam int NEAR_W    = 16;
  localparam int FAR_W     = 16;
  localparam int FAR_SH_W  = FAR_W + 8;           // far in 1/65536
  localparam int PROD_W    = NEAR_W + FAR_W;      // near*(far-d)
  localparam int DEN_W     = DIST_W + FAR_SH_W;   // d*(far*256-near)
  localparam int REM_W     = DEN_W + 1;
  localparam int QV_W      = VALUE_BITS;
  localparam int QD_W      = VALUE_BITS + 2;
  localparam int QSHIFT    = FX_BITS - VALUE_BITS;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  localparam logic [FX_W-1:0] ONE_FX = FX_W'(1 << FX_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR  = 2'd0,
    REG_FAR   = 2'd1,
    REG_KNOT  = 2'd2,
    REG_FADE  = 2'd3
  } cfg_reg_t;

endpackage

// ----- rtl/fog_lut_visibility_eval_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fog_lut_visibility_eval_unit
// Maps a view distance to a perspective fog table position and returns the
// linearly interpolated, quantized fog visibility together with the entry.
// ----------------------------------------------------------------------------
// The 24-stage radix-2 divider makes up most of the pipeline. Throughput: one
// request per cycle while in_stall is low.
// Each stage holds its data under downstream stall, so bubbles collapse.
// Reset (rst_n low, synchronous): pipeline emptied, registers return to
// near 6554, far 51200, knot level 0, fade strength 65536.
module fog_lut_visibility_eval_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [fogvis_pkg::DIST_W-1:0]       in_distance,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [fogvis_pkg::FX_W-1:0]         out_visibility,
  output logic [fogvis_pkg::ENTRY_W-1:0]      out_table_entry,
  input  logic                                cfg_we,
  input  logic [fogvis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fogvis_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import fogvis_pkg::*;

  // Stage map: 0 = multiply, 1 = divider seed, 2..QUO_W+1 = divider steps,
  // then knot select, difference multiply, accumulate/output.
  localparam int ST_DIV0 = 1;
  localparam int ST_SEL  = QUO_W + 2;
  localparam int ST_MUL  = ST_SEL + 1;
  localparam int ST_OUT  = ST_MUL + 1;
  localparam int NST     = ST_OUT + 1;

  // --------------------------------------------------------------------------
  // Configuration registers and derived knots
  // --------------------------------------------------------------------------
  logic [NEAR_W-1:0] near_r;
  logic [FAR_W-1:0]  far_r;
  logic [FX_W-1:0]   knot_r;
  logic [FX_W-1:0]   fade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= NEAR_W'(6554);
      far_r  <= FAR_W'(51200);
      knot_r <= '0;
      fade_r <= ONE_FX;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NEAR: near_r <= cfg_data[NEAR_W-1:0];
        REG_FAR:  far_r  <= cfg_data[FAR_W-1:0];
        REG_KNOT: knot_r <= cfg_data[FX_W-1:0];
        REG_FADE: fade_r <= cfg_data[FX_W-1:0];
        default:  ;
      endcase
    end
  end

  // Blended knots: entry 0, entries below the clear knot. Beyond is 1.0.
  logic [FX_W-1:0]     fade_sat, lvl_sat, one_m_s, one_m_v;
  logic [2*FX_W-1:0]   blend_prod;
  logic [FX_W-1:0]     k_zero_nxt, k_mid_nxt;
  logic [FX_W-1:0]     k_zero_r, k_mid_r;

  always_comb begin
    fade_sat   = (fade_r > ONE_FX) ? ONE_FX : fade_r;
    lvl_sat    = (knot_r > ONE_FX) ? ONE_FX : knot_r;
    one_m_s    = ONE_FX - fade_sat;
    one_m_v    = ONE_FX - lvl_sat;
    blend_prod = one_m_s * one_m_v;
    k_zero_nxt = one_m_s;
    k_mid_nxt  = lvl_sat + blend_prod[FX_BITS +: FX_W];
  end

  always_ff @(posedge clk) begin
    k_zero_r <= k_zero_nxt;
    k_mid_r  <= k_mid_nxt;
  end

  // --------------------------------------------------------------------------
  // Pipeline flow: a stage loads when it is empty or its successor moves.
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] go;

  always_comb begin
    go[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      go[k] = !vld_r[k] || go[k+1];
    end
  end

  assign in_stall = !go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (go[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: numerator and denominator products, special cases
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]   num_nxt, num_r;
  logic [DEN_W-1:0]    den_nxt, den0_r;
  logic [FAR_SH_W-1:0] far_sh, span;
  logic                full0_nxt, full0_r, zero0_nxt, zero0_r;

  always_comb begin
    far_sh    = {far_r, 8'd0};
    span      = far_sh - FAR_SH_W'(near_r);
    num_nxt   = near_r * (far_r - in_distance);
    den_nxt   = in_distance * span;
    full0_nxt = (in_distance == '0) || (far_sh <= FAR_SH_W'(near_r));
    zero0_nxt = in_distance >= far_r;
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      num_r   <= num_nxt;
      den0_r  <= den_nxt;
      full0_r <= full0_nxt;
      zero0_r <= zero0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: numerator = num * 2^(QUO_W-1). Top part num>>1 seeds the
  // remainder (overflow if it reaches den), then one quotient bit per stage.
  // --------------------------------------------------------------------------
  logic [REM_W-1:0] rem_r  [ST_DIV0:ST_SEL-1];
  logic [QUO_W-1:0] quo_r  [ST_DIV0:ST_SEL-1];
  logic [DEN_W-1:0] den_r  [ST_DIV0:ST_SEL-1];
  logic             bit0_r [ST_DIV0:ST_SEL-1];
  logic             full_r [ST_DIV0:ST_SEL-1];
  logic             zero_r [ST_DIV0:ST_SEL-1];

  always_ff @(posedge clk) begin
    if (go[ST_DIV0]) begin
      rem_r[ST_DIV0]  <= REM_W'(num_r >> 1);
      quo_r[ST_DIV0]  <= '0;
      den_r[ST_DIV0]  <= den0_r;
      bit0_r[ST_DIV0] <= num_r[0];
      // quotient would exceed 2^QUO_W: clamp to full
      full_r[ST_DIV0] <= full0_r || (!zero0_r && (DEN_W'(num_r >> 1) >= den0_r));
      zero_r[ST_DIV0] <= zero0_r;
    end
  end

  for (genvar j = ST_DIV0 + 1; j < ST_SEL; j++) begin : g_div
    logic [REM_W-1:0] shl;
    logic             take;
    assign shl  = {rem_r[j-1][REM_W-2:0], (j == ST_DIV0 + 1) ? bit0_r[j-1] : 1'b0};
    assign take = shl >= {1'b0, den_r[j-1]};
    always_ff @(posedge clk) begin
      if (go[j]) begin
        rem_r[j]  <= take ? shl - {1'b0, den_r[j-1]} : shl;
        quo_r[j]  <= {quo_r[j-1][QUO_W-2:0], take};
        den_r[j]  <= den_r[j-1];
        bit0_r[j] <= bit0_r[j-1];
        full_r[j] <= full_r[j-1];
        zero_r[j] <= zero_r[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Select stage: clamp position, split entry/fraction, quantize knots
  // --------------------------------------------------------------------------
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(LUT_SIZE) << FX_BITS;

  logic [POS_W-1:0]   pos;
  logic [ENTRY_W:0]   lo_wide;
  logic [ENTRY_W-1:0] lo;
  logic [FX_W-1:0]    frac;
  logic [FX_W-1:0]    k_a, k_b;
  logic [FX_W-QSHIFT-1:0] qa;
  logic [QV_W-1:0]    qv_nxt;
  logic [FX_W:0]      kdiff;
  logic [FX_W-QSHIFT-1:0] dmag;
  logic signed [QD_W-1:0] qd_nxt;

  function automatic logic [FX_W-1:0] knot_of(input logic [ENTRY_W:0] idx,
                                              input logic [FX_W-1:0] kz,
                                              input logic [FX_W-1:0] km);
    if (idx == '0) return kz;
    else if (idx < (ENTRY_W+1)'(CLEAR_KNOT)) return km;
    else return ONE_FX;
  endfunction

  always_comb begin
    if (full_r[ST_SEL-1]) begin
      pos = POS_FULL;
    end else if (zero_r[ST_SEL-1]) begin
      pos = '0;
    end else begin
      pos = (quo_r[ST_SEL-1] > POS_FULL) ? POS_FULL : quo_r[ST_SEL-1];
    end
    lo_wide = pos[POS_W-1:FX_BITS];
    lo      = (lo_wide >= (ENTRY_W+1)'(LUT_SIZE)) ? ENTRY_W'(LUT_SIZE - 1)
                                                  : lo_wide[ENTRY_W-1:0];
    frac    = FX_W'(pos - (POS_W'(lo) << FX_BITS));
    k_a     = knot_of({1'b0, lo}, k_zero_r, k_mid_r);
    k_b     = knot_of({1'b0, lo} + 1'b1, k_zero_r, k_mid_r);
    qa      = k_a[FX_W-1:QSHIFT];
    qv_nxt  = (qa > (FX_W-QSHIFT)'((1 << VALUE_BITS) - 1))
              ? QV_W'((1 << VALUE_BITS) - 1) : qa[QV_W-1:0];
    if (k_b >= k_a) begin
      kdiff  = {1'b0, k_b - k_a};
      dmag   = kdiff[FX_W-1:QSHIFT];
      qd_nxt = (dmag > (FX_W-QSHIFT)'((1 << (VALUE_BITS + 1)) - 1))
               ? QD_W'((1 << (VALUE_BITS + 1)) - 1) : QD_W'(dmag);
    end else begin
      kdiff  = {1'b0, k_a - k_b};
      dmag   = kdiff[FX_W-1:QSHIFT];
      qd_nxt = (dmag > (FX_W-QSHIFT)'(1 << (VALUE_BITS + 1)))
               ? QD_W'(1 << (VALUE_BITS + 1)) : -QD_W'(dmag);
    end
    if (lo == ENTRY_W'(LUT_SIZE - 1)) qd_nxt = '0;
  end

  logic [ENTRY_W-1:0]     sel_lo_r;
  logic [FX_W-1:0]        sel_frac_r;
  logic [QV_W-1:0]        sel_qv_r;
  logic signed [QD_W-1:0] sel_qd_r;

  always_ff @(posedge clk) begin
    if (go[ST_SEL]) begin
      sel_lo_r   <= lo;
      sel_frac_r <= frac;
      sel_qv_r   <= qv_nxt;
      sel_qd_r   <= qd_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Multiply stage: fraction * difference
  // --------------------------------------------------------------------------
  localparam int MP_W = FX_W + QD_W + 1;

  logic signed [MP_W-1:0] mp_nxt, mul_prod_r;
  logic [ENTRY_W-1:0]     mul_lo_r;
  logic [QV_W-1:0]        mul_qv_r;

  assign mp_nxt = $signed({1'b0, sel_frac_r}) * sel_qd_r;

  always_ff @(posedge clk) begin
    if (go[ST_MUL]) begin
      mul_prod_r <= mp_nxt;
      mul_lo_r   <= sel_lo_r;
      mul_qv_r   <= sel_qv_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: value*65536 + product, clamp, scale
  // --------------------------------------------------------------------------
  localparam int TOT_W = MP_W + 2;

  logic signed [TOT_W-1:0] total;
  logic [TOT_W-1:0]        vis_wide;
  logic [FX_W-1:0]         vis_nxt;
  logic [FX_W-1:0]         out_vis_r;
  logic [ENTRY_W-1:0]      out_lo_r;

  always_comb begin
    total    = $signed(TOT_W'(mul_qv_r) << FX_BITS) + TOT_W'(mul_prod_r);
    vis_wide = (total < 0) ? '0 : (TOT_W'(total) >> VALUE_BITS);
    vis_nxt  = (vis_wide > TOT_W'(ONE_FX)) ? ONE_FX : vis_wide[FX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (go[ST_OUT]) begin
      out_vis_r <= vis_nxt;
      out_lo_r  <= mul_lo_r;
    end
  end

  assign out_valid       = vld_r[ST_OUT];
  assign out_visibility  = out_vis_r;
  assign out_table_entry = out_lo_r;

endmodule
